### sv/bfc_pkg.sv
package bfc_pkg;

  localparam int BITMAP_BITS = 256;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int CNT_W       = 9;
  localparam int HI_W        = CNT_W - BIT_IDX_W;

  localparam int OP_W     = 4;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_TEST         = 4'd0,
    OP_SET          = 4'd1,
    OP_CLEAR        = 4'd2,
    OP_TOGGLE       = 4'd3,
    OP_SET_IF_ZERO  = 4'd4,
    OP_CLEAR_IF_ONE = 4'd5,
    OP_HIGH_ONE     = 4'd6,
    OP_HIGH_ZERO    = 4'd7,
    OP_LOW_ONE      = 4'd8,
    OP_LOW_ZERO     = 4'd9
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_NO_DATA = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_SCAN,
    S_DONE
  } state_t;

  // request to the find unit
  typedef struct packed {
    word_t word;
    word_t mask;
    logic  want;
    logic  high;
  } find_req_t;

  // answer of the find unit
  typedef struct packed {
    logic     found;
    bit_idx_t bit_pos;
  } find_rsp_t;

endpackage

### sv/bfc_in_if.sv
interface bfc_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfc_pkg::OP_W-1:0]       op;
  logic [bfc_pkg::INDEX_W-1:0]    bit_index;

  modport source (output valid, output op, output bit_index, input ready);
  modport sink (input valid, input op, input bit_index, output ready);
endinterface

### sv/bfc_out_if.sv
interface bfc_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfc_pkg::STATUS_W-1:0]   status;
  logic                           bit_value;
  logic [bfc_pkg::POS_W-1:0]      position;

  modport source (output valid, output status, output bit_value, output position,
                  input ready);
  modport sink (input valid, input status, input bit_value, input position,
                output ready);
endinterface

### sv/bfc_find_unit.sv
module bfc_find_unit (
  input  bfc_pkg::find_req_t req,
  output bfc_pkg::find_rsp_t rsp
);

  bfc_pkg::word_t    cand;
  bfc_pkg::word_t    cand_ord;
  bfc_pkg::bit_idx_t low_pos;

  // candidates are bits equal to the wanted value inside the search window
  assign cand = (req.want ? req.word : ~req.word) & req.mask;

  // highest search runs as a lowest search on the bit-reversed word
  always_comb begin
    for (int i = 0; i < bfc_pkg::WORD_BITS; i++) begin
      cand_ord[i] = req.high ? cand[bfc_pkg::WORD_BITS-1-i] : cand[i];
    end
  end

  always_comb begin
    low_pos = '0;
    for (int i = bfc_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand_ord[i]) begin
        low_pos = bfc_pkg::BIT_IDX_W'(i);
      end
    end
  end

  assign rsp.found   = |cand;
  assign rsp.bit_pos = req.high ? bfc_pkg::BIT_IDX_W'(bfc_pkg::WORD_BITS - 1) - low_pos
                                : low_pos;

endmodule

### sv/bitmap_find_and_claim_core.sv
// sequence: bit operations pass through S_BIT and S_DONE, searches through S_SCAN
// (word by word, up to eight bitmap words) and S_DONE, and unused op codes or a
// search over an empty span go straight to S_DONE; S_DONE loads the output register
// throughput: one request at a time, the next is taken only after the result has
// entered the output register, which waits while out_ch stalls
// reset: rst_n is synchronous active low, clears the bitmap to all zero, sets
// bits_in_use to 256 and empties the output register
module bitmap_find_and_claim_core (
  input  logic                      clk,
  input  logic                      rst_n,
  bfc_in_if.sink                    in_ch,
  bfc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [bfc_pkg::CNT_W-1:0] cfg_wdata
);

  // bitmap storage, one word read and one word written per cycle
  bfc_pkg::word_t bitmap_r [bfc_pkg::NUM_WORDS];

  bfc_pkg::state_t state_r, state_nxt;

  // configuration
  bfc_pkg::cnt_t bits_in_use_r;

  // latched request
  logic [bfc_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [bfc_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  bfc_pkg::cnt_t               n_r, n_nxt;
  bfc_pkg::word_idx_t          last_r, last_nxt;
  bfc_pkg::word_idx_t          ptr_r, ptr_nxt;

  // pending result
  logic [bfc_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                         res_bv_r, res_bv_nxt;
  logic [bfc_pkg::POS_W-1:0]    res_pos_r, res_pos_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [bfc_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                         out_bv_r, out_bv_nxt;
  logic [bfc_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;

  // memory access
  bfc_pkg::word_idx_t rd_addr;
  bfc_pkg::word_t     rd_word;
  logic               wr_en;
  bfc_pkg::word_idx_t wr_addr;
  bfc_pkg::word_t     wr_word;

  // request decode at accept time
  logic          in_fire;
  bfc_pkg::cnt_t n_sat;
  bfc_pkg::cnt_t n_m1;

  // bit operation datapath
  bfc_pkg::cnt_t      idx_ext;
  logic               idx_ok;
  bfc_pkg::word_idx_t idx_word;
  bfc_pkg::bit_idx_t  idx_bit;
  logic               bit_old;

  // search datapath
  logic                 op_high;
  logic                 op_want;
  logic [bfc_pkg::HI_W-1:0] ptr_ext;
  bfc_pkg::find_req_t   find_req;
  bfc_pkg::find_rsp_t   find_rsp;
  logic                 scan_last;

  bfc_find_unit u_find (
    .req (find_req),
    .rsp (find_rsp)
  );

  assign in_ch.ready   = (state_r == bfc_pkg::S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.bit_value = out_bv_r;
  assign out_ch.position  = out_pos_r;

  // bits_in_use above the bitmap size saturates
  assign n_sat = (bits_in_use_r > bfc_pkg::CNT_W'(bfc_pkg::BITMAP_BITS))
               ? bfc_pkg::CNT_W'(bfc_pkg::BITMAP_BITS) : bits_in_use_r;
  assign n_m1  = n_sat - bfc_pkg::CNT_W'(1);

  // addressed bit; positions past the bitmap read as zero and are never written
  assign idx_ext  = bfc_pkg::CNT_W'(idx_r);
  assign idx_ok   = idx_ext < bfc_pkg::CNT_W'(bfc_pkg::BITMAP_BITS);
  assign idx_word = idx_ext[bfc_pkg::BIT_IDX_W +: bfc_pkg::WORD_IDX_W];
  assign idx_bit  = idx_ext[bfc_pkg::BIT_IDX_W-1:0];

  assign rd_addr = (state_r == bfc_pkg::S_BIT) ? idx_word : ptr_r;
  assign rd_word = bitmap_r[rd_addr];
  assign bit_old = idx_ok && rd_word[idx_bit];

  // search direction and wanted bit value
  assign op_high = (op_r == bfc_pkg::OP_HIGH_ONE) || (op_r == bfc_pkg::OP_HIGH_ZERO);
  assign op_want = (op_r == bfc_pkg::OP_HIGH_ONE) || (op_r == bfc_pkg::OP_LOW_ONE);

  // window of the current word that lies below bits_in_use
  assign ptr_ext = bfc_pkg::HI_W'(ptr_r);
  always_comb begin
    find_req.word = rd_word;
    find_req.want = op_want;
    find_req.high = op_high;
    priority if (ptr_ext < n_r[bfc_pkg::CNT_W-1:bfc_pkg::BIT_IDX_W]) begin
      find_req.mask = '1;
    end else if (ptr_ext == n_r[bfc_pkg::CNT_W-1:bfc_pkg::BIT_IDX_W]) begin
      find_req.mask = (bfc_pkg::WORD_BITS'(1) << n_r[bfc_pkg::BIT_IDX_W-1:0])
                    - bfc_pkg::WORD_BITS'(1);
    end else begin
      find_req.mask = '0;
    end
  end

  // low searches end at the top word in use, high searches at word zero
  assign scan_last = op_high ? (ptr_r == '0) : (ptr_r == last_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    last_nxt       = last_r;
    ptr_nxt        = ptr_r;
    res_status_nxt = res_status_r;
    res_bv_nxt     = res_bv_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_bv_nxt     = out_bv_r;
    out_pos_nxt    = out_pos_r;
    wr_en          = 1'b0;
    wr_addr        = idx_word;
    wr_word        = rd_word;

    unique case (state_r)
      bfc_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_ch.op;
          idx_nxt        = in_ch.bit_index;
          n_nxt          = n_sat;
          last_nxt       = n_m1[bfc_pkg::BIT_IDX_W +: bfc_pkg::WORD_IDX_W];
          res_status_nxt = bfc_pkg::ST_DONE;
          res_bv_nxt     = 1'b0;
          res_pos_nxt    = '0;
          priority if (in_ch.op <= bfc_pkg::OP_CLEAR_IF_ONE) begin
            state_nxt = bfc_pkg::S_BIT;
          end else if (in_ch.op <= bfc_pkg::OP_LOW_ZERO) begin
            if (n_sat == '0) begin
              // nothing to search
              res_status_nxt = bfc_pkg::ST_NO_DATA;
              state_nxt      = bfc_pkg::S_DONE;
            end else begin
              ptr_nxt   = ((in_ch.op == bfc_pkg::OP_HIGH_ONE) ||
                           (in_ch.op == bfc_pkg::OP_HIGH_ZERO))
                        ? n_m1[bfc_pkg::BIT_IDX_W +: bfc_pkg::WORD_IDX_W] : '0;
              state_nxt = bfc_pkg::S_SCAN;
            end
          end else begin
            // unused op code: all-zero result, no change
            state_nxt = bfc_pkg::S_DONE;
          end
        end
      end

      bfc_pkg::S_BIT: begin
        res_bv_nxt = bit_old;
        wr_en      = idx_ok && (op_r != bfc_pkg::OP_TEST);
        wr_addr    = idx_word;
        unique case (op_r)
          bfc_pkg::OP_SET:    wr_word[idx_bit] = 1'b1;
          bfc_pkg::OP_CLEAR:  wr_word[idx_bit] = 1'b0;
          bfc_pkg::OP_TOGGLE: wr_word[idx_bit] = ~bit_old;
          bfc_pkg::OP_SET_IF_ZERO: begin
            if (bit_old) begin
              res_status_nxt = bfc_pkg::ST_REFUSED;
            end
            wr_word[idx_bit] = 1'b1;
          end
          bfc_pkg::OP_CLEAR_IF_ONE: begin
            if (!bit_old) begin
              res_status_nxt = bfc_pkg::ST_REFUSED;
            end
            wr_word[idx_bit] = 1'b0;
          end
          default: wr_en = 1'b0;
        endcase
        state_nxt = bfc_pkg::S_DONE;
      end

      bfc_pkg::S_SCAN: begin
        if (find_rsp.found) begin
          // claim the found bit by flipping it
          wr_en          = 1'b1;
          wr_addr        = ptr_r;
          wr_word        = rd_word;
          wr_word[find_rsp.bit_pos] = ~op_want;
          res_status_nxt = bfc_pkg::ST_DONE;
          res_bv_nxt     = op_want;
          res_pos_nxt    = bfc_pkg::POS_W'({ptr_r, find_rsp.bit_pos});
          state_nxt      = bfc_pkg::S_DONE;
        end else if (scan_last) begin
          res_status_nxt = bfc_pkg::ST_NO_DATA;
          state_nxt      = bfc_pkg::S_DONE;
        end else begin
          ptr_nxt = op_high ? ptr_r - bfc_pkg::WORD_IDX_W'(1)
                            : ptr_r + bfc_pkg::WORD_IDX_W'(1);
        end
      end

      bfc_pkg::S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_bv_nxt     = res_bv_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = bfc_pkg::S_IDLE;
        end
      end

      default: state_nxt = bfc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bfc_pkg::S_IDLE;
      out_valid_r   <= 1'b0;
      bits_in_use_r <= bfc_pkg::CNT_W'(256);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bits_in_use_r <= cfg_wdata;
      end
    end
  end

  // bitmap words, all zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bfc_pkg::NUM_WORDS; i++) begin
        bitmap_r[i] <= '0;
      end
    end else if (wr_en) begin
      bitmap_r[wr_addr] <= wr_word;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    last_r       <= last_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_bv_r     <= res_bv_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_bv_r     <= out_bv_nxt;
    out_pos_r    <= out_pos_nxt;
  end

endmodule
